/* hw/rtl/md5_pkg.sv */
// ----------------------------------------------------------------------------
// MD5 package
// Shared constants, types and round functions for the MD5 stream hasher.
// ----------------------------------------------------------------------------
package md5_pkg;

  localparam int unsigned BlockBytes  = 64;
  localparam int unsigned IdxW        = 6;
  localparam int unsigned CountW      = 61;
  localparam int unsigned QueueDepth  = 4;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;
  localparam logic [7:0]  PadByte = 8'h80;

  typedef enum logic {
    OP_ABSORB = 1'b0,
    OP_FINISH = 1'b1
  } op_e;

  // classified word handed from front to back
  typedef struct packed {
    logic       finish;
    logic [7:0] data;
  } cmd_t;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    begin
      unique case (i)
        6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756; 6'd2:  k = 32'h242070db;
        6'd3:  k = 32'hc1bdceee; 6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
        6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501; 6'd8:  k = 32'h698098d8;
        6'd9:  k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
        6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
        6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
        6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
        6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
        6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
        6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
        6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
        6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
        6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
        6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
        6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
        6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
        6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
        6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
        6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
        6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
        6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
        default: k = 32'heb86d391;
      endcase
      return k;
    end
  endfunction

  function automatic logic [4:0] round_s(input logic [5:0] i);
    logic [4:0] s;
    begin
      unique case ({i[5:4], i[1:0]})
        4'd0:  s = 5'd7;  4'd1:  s = 5'd12; 4'd2:  s = 5'd17; 4'd3:  s = 5'd22;
        4'd4:  s = 5'd5;  4'd5:  s = 5'd9;  4'd6:  s = 5'd14; 4'd7:  s = 5'd20;
        4'd8:  s = 5'd4;  4'd9:  s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
        4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
      endcase
      return s;
    end
  endfunction

  // message word index for round i
  function automatic logic [3:0] round_g(input logic [5:0] i);
    logic [3:0] g;
    begin
      unique case (i[5:4])
        2'd0:    g = i[3:0];
        2'd1:    g = 4'(5 * i[3:0] + 1);
        2'd2:    g = 4'(3 * i[3:0] + 5);
        default: g = 4'(7 * i[3:0]);
      endcase
      return g;
    end
  endfunction

  function automatic logic [31:0] byte_swap(input logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

endpackage

/* hw/rtl/md5_if.sv */
// ----------------------------------------------------------------------------
// MD5 stream interfaces
// Valid/ready channels for input words and digest words.
// ----------------------------------------------------------------------------
interface md5_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;
  modport source (output valid, output op, output data_byte, input ready);
  modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface md5_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_half;
  logic        digest_last;
  modport source (output valid, output digest_half, output digest_last, input ready);
  modport sink   (input valid, input digest_half, input digest_last, output ready);
endinterface

/* hw/rtl/md5_stream_hasher.sv */
// ----------------------------------------------------------------------------
// MD5 stream hasher
// Byte-serial MD5 with a word queue in front of a round-per-cycle core.
// ----------------------------------------------------------------------------
// Each absorb word stores one byte, taken only while the core is idle; every
// 64th byte starts a compression that loads the block byte by byte (one
// buffer RAM read port) and then runs 64 rounds. A finish pads, compresses
// one or two blocks and then offers the digest as two 64-bit words, first
// half then last. A four-entry queue lets input words keep arriving while
// the core compresses.
module md5_stream_hasher #(
  parameter int unsigned QueueDepth = md5_pkg::QueueDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  md5_in_if.sink    in_i,
  md5_out_if.source out_o
);
  import md5_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_ready;

  md5_front #(.Depth(QueueDepth)) u_front (
    .clk_i, .rst_ni, .in_i,
    .cmd_o(cmd), .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready)
  );

  md5_core u_core (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready),
    .out_o
  );
endmodule

/* hw/rtl/md5_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module md5_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

/* hw/rtl/md5_front.sv */
// ----------------------------------------------------------------------------
// MD5 front end
// Accepts input words, classifies them and queues them for the core.
// ----------------------------------------------------------------------------
module md5_front #(
  parameter int unsigned Depth = md5_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  md5_in_if.sink        in_i,
  output md5_pkg::cmd_t cmd_o,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i
);
  import md5_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);

  cmd_t            fifo_q [Depth];
  logic [PtrW-1:0] rd_q, wr_q;
  logic [PtrW:0]   cnt_q;
  logic            push, pop;

  assign in_i.ready  = (cnt_q != (PtrW+1)'(Depth));
  assign push        = in_i.valid && in_i.ready;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = fifo_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= '{finish: (op_e'(in_i.op) == OP_FINISH), data: in_i.data_byte};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrW'(Depth-1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PtrW'(Depth-1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end
  end
endmodule

/* hw/rtl/md5_core.sv */
// ----------------------------------------------------------------------------
// MD5 core
// Buffers bytes, pads, runs one round per cycle and emits the digest.
// ----------------------------------------------------------------------------
module md5_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  md5_pkg::cmd_t cmd_i,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  md5_out_if.source     out_o
);
  import md5_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PAD, S_LOAD, S_ROUND, S_FOLD, S_OUT0, S_OUT1
  } state_e;

  state_e               state_q;
  logic [CountW-1:0]    count_q;
  logic [IdxW-1:0]      ptr_q;
  logic                 fin_q, last_q;
  logic [31:0]          ca_q, cb_q, cc_q, cd_q;
  logic [31:0]          a_q, b_q, c_q, d_q;
  logic [5:0]           rnd_q;
  logic [3:0]           ld_q;
  logic [1:0]           lb_q;
  logic [31:0]          m_q [16];
  logic [31:0]          wacc_q;
  logic                 rvalid_q;
  logic [3:0]           rword_q;
  logic [1:0]           rbyte_q;

  logic                 we;
  logic [IdxW-1:0]      waddr, raddr;
  logic [7:0]           wdata, rdata;
  logic [63:0]          bits;
  logic [31:0]          f, sum, rot;
  logic [4:0]           sh;

  md5_ram #(.Width(8), .Depth(BlockBytes)) u_buf (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign bits        = {count_q, 3'b000};
  assign cmd_ready_o = (state_q == S_IDLE);
  assign raddr       = {ld_q, lb_q};

  always_comb begin
    we    = 1'b0;
    waddr = ptr_q;
    wdata = 8'h00;
    if (state_q == S_IDLE && cmd_valid_i) begin
      we    = 1'b1;
      wdata = cmd_i.finish ? PadByte : cmd_i.data;
    end else if (state_q == S_PAD) begin
      we = 1'b1;
      if (!last_q && ptr_q >= IdxW'(56)) begin
        wdata = bits[8*(ptr_q[2:0]) +: 8];
      end
    end
  end

  always_comb begin
    unique case (rnd_q[5:4])
      2'd0:    f = (b_q & c_q) | (~b_q & d_q);
      2'd1:    f = (b_q & d_q) | (c_q & ~d_q);
      2'd2:    f = b_q ^ c_q ^ d_q;
      default: f = c_q ^ (b_q | ~d_q);
    endcase
    sum = a_q + f + round_k(rnd_q) + m_q[round_g(rnd_q)];
    sh  = round_s(rnd_q);
    rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
  end

  always_ff @(posedge clk_i) begin
    if (rvalid_q) begin
      m_q[rword_q] <= {rdata, wacc_q[31:8]};
      wacc_q       <= {rdata, wacc_q[31:8]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      ptr_q    <= '0;
      fin_q    <= 1'b0;
      last_q   <= 1'b0;
      ca_q <= InitA; cb_q <= InitB; cc_q <= InitC; cd_q <= InitD;
      a_q <= '0; b_q <= '0; c_q <= '0; d_q <= '0;
      rnd_q    <= '0;
      ld_q     <= '0;
      lb_q     <= '0;
      rvalid_q <= 1'b0;
      rword_q  <= '0;
      rbyte_q  <= '0;
      out_o.valid       <= 1'b0;
      out_o.digest_half <= '0;
      out_o.digest_last <= 1'b0;
    end else begin
      rvalid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            ptr_q <= ptr_q + 1'b1;
            if (cmd_i.finish) begin
              fin_q  <= 1'b1;
              last_q <= (ptr_q >= IdxW'(56));
              state_q <= (ptr_q == IdxW'(63)) ? S_LOAD : S_PAD;
              ld_q <= '0; lb_q <= '0;
            end else begin
              count_q <= count_q + 1'b1;
              fin_q   <= 1'b0;
              if (ptr_q == IdxW'(63)) begin
                state_q <= S_LOAD;
                ld_q <= '0; lb_q <= '0;
              end
            end
          end
        end
        // fill zeros and length; last_q marks an overflow block
        S_PAD: begin
          ptr_q <= ptr_q + 1'b1;
          if (ptr_q == IdxW'(63)) begin
            state_q <= S_LOAD;
            ld_q <= '0; lb_q <= '0;
          end else if (ptr_q == IdxW'(55) && !last_q && ptr_q != IdxW'(63)) begin
            state_q <= S_PAD;
          end
        end
        S_LOAD: begin
          rvalid_q <= 1'b1;
          rword_q  <= ld_q;
          rbyte_q  <= lb_q;
          {ld_q, lb_q} <= {ld_q, lb_q} + 1'b1;
          if ({ld_q, lb_q} == IdxW'(63)) begin
            state_q <= S_ROUND;
            rnd_q   <= '0;
            a_q <= ca_q; b_q <= cb_q; c_q <= cc_q; d_q <= cd_q;
          end
        end
        S_ROUND: begin
          if (rvalid_q || rbyte_q != 2'd3) begin
            state_q <= S_ROUND;
          end
          a_q <= d_q;
          d_q <= c_q;
          c_q <= b_q;
          b_q <= b_q + rot;
          rnd_q <= rnd_q + 1'b1;
          if (rnd_q == 6'd63) begin
            state_q <= S_FOLD;
          end
        end
        S_FOLD: begin
          ca_q <= ca_q + a_q;
          cb_q <= cb_q + b_q;
          cc_q <= cc_q + c_q;
          cd_q <= cd_q + d_q;
          if (fin_q && last_q) begin
            last_q  <= 1'b0;
            state_q <= S_PAD;
          end else if (fin_q) begin
            state_q <= S_OUT0;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_OUT0: begin
          if (!out_o.valid) begin
            out_o.valid       <= 1'b1;
            out_o.digest_half <= {byte_swap(ca_q), byte_swap(cb_q)};
            out_o.digest_last <= 1'b0;
          end else if (out_o.ready) begin
            out_o.digest_half <= {byte_swap(cc_q), byte_swap(cd_q)};
            out_o.digest_last <= 1'b1;
            state_q <= S_OUT1;
          end
        end
        S_OUT1: begin
          if (out_o.ready) begin
            out_o.valid <= 1'b0;
            ca_q <= InitA; cb_q <= InitB; cc_q <= InitC; cd_q <= InitD;
            count_q <= '0;
            ptr_q   <= '0;
            fin_q   <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// MD5 stream hasher testbench
// Feeds byte messages with random lengths (padding boundaries favored) and
// finish words, predicts each digest with an independent MD5 model and
// compares every digest word as it leaves the block, under varied idling.
// ----------------------------------------------------------------------------
module tb;
  import md5_pkg::*;

  typedef struct {
    op_e        op;
    logic [7:0] data;
  } in_word_t;

  typedef struct {
    logic [63:0] half;
    logic        last;
  } digest_word_t;

  localparam int unsigned WatchLimit = 20000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned DrainCycles = 400;

  logic clk_i;
  logic rst_ni;

  md5_in_if  in_ch ();
  md5_out_if out_ch ();

  md5_stream_hasher dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  in_word_t     pending_words[$];
  digest_word_t digest_queue[$];
  in_word_t     drv_word;

  logic [31:0] md_chain[4];
  logic [7:0]  md_buf[64];
  logic [60:0] md_count;

  int unsigned src_idle;
  int unsigned sink_idle;
  int unsigned errors;
  int unsigned quiet_cycles;
  int unsigned hold_left;
  bit          hold_req;
  bit          hold_taken;

  logic [31:0] kt[64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee, 32'hf57c0faf, 32'h4787c62a,
    32'ha8304613, 32'hfd469501, 32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821, 32'hf61e2562, 32'hc040b340,
    32'h265e5a51, 32'he9b6c7aa, 32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed, 32'ha9e3e905, 32'hfcefa3f8,
    32'h676f02d9, 32'h8d2a4c8a, 32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70, 32'h289b7ec6, 32'heaa127fa,
    32'hd4ef3085, 32'h04881d05, 32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039, 32'h655b59c3, 32'h8f0ccc92,
    32'hffeff47d, 32'h85845dd1, 32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
  int unsigned st[16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic [31:0] rotl(logic [31:0] x, int unsigned s);
    return (x << s) | (x >> (32 - s));
  endfunction

  function automatic logic [31:0] lsb_first(logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  task automatic md_init();
    md_chain = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};
    md_count = '0;
  endtask

  task automatic md_compress();
    logic [31:0] m[16];
    logic [31:0] a, b, c, d, f, t;
    int unsigned g;
    for (int i = 0; i < 16; i++)
      m[i] = {md_buf[4*i+3], md_buf[4*i+2], md_buf[4*i+1], md_buf[4*i]};
    a = md_chain[0]; b = md_chain[1]; c = md_chain[2]; d = md_chain[3];
    for (int i = 0; i < 64; i++) begin
      if (i < 16) begin
        f = (b & c) | (~b & d); g = i;
      end else if (i < 32) begin
        f = (b & d) | (c & ~d); g = (5 * i + 1) % 16;
      end else if (i < 48) begin
        f = b ^ c ^ d; g = (3 * i + 5) % 16;
      end else begin
        f = c ^ (b | ~d); g = (7 * i) % 16;
      end
      t = d; d = c; c = b;
      b = b + rotl(a + f + kt[i] + m[g], st[(i / 16) * 4 + i % 4]);
      a = t;
    end
    md_chain[0] += a; md_chain[1] += b; md_chain[2] += c; md_chain[3] += d;
  endtask

  task automatic md_apply(in_word_t w);
    int unsigned used;
    logic [63:0] bits;
    digest_word_t dw;
    used = md_count[5:0];
    if (w.op == OP_ABSORB) begin
      md_buf[used] = w.data;
      md_count = md_count + 1'b1;
      if (used == 63) md_compress();
    end else begin
      md_buf[used] = 8'h80;
      used++;
      if (used > 56) begin
        for (int i = used; i < 64; i++) md_buf[i] = 8'h00;
        md_compress();
        used = 0;
      end
      for (int i = used; i < 56; i++) md_buf[i] = 8'h00;
      bits = {md_count, 3'b000};
      for (int i = 0; i < 8; i++) md_buf[56+i] = bits[8*i +: 8];
      md_compress();
      dw.half = {lsb_first(md_chain[0]), lsb_first(md_chain[1])};
      dw.last = 1'b0;
      digest_queue.push_back(dw);
      dw.half = {lsb_first(md_chain[2]), lsb_first(md_chain[3])};
      dw.last = 1'b1;
      digest_queue.push_back(dw);
      md_init();
    end
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  task automatic push_msg(int unsigned len);
    in_word_t w;
    for (int unsigned i = 0; i < len; i++) begin
      w.op = OP_ABSORB;
      w.data = 8'($urandom);
      pending_words.push_back(w);
    end
    w.op = OP_FINISH;
    w.data = 8'($urandom);
    pending_words.push_back(w);
  endtask

  task automatic push_bytes_and_finish(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2, int n);
    in_word_t w;
    logic [7:0] bs[3];
    bs = '{b0, b1, b2};
    for (int i = 0; i < n; i++) begin
      w.op = OP_ABSORB; w.data = bs[i];
      pending_words.push_back(w);
    end
    w.op = OP_FINISH; w.data = 8'hff;
    pending_words.push_back(w);
  endtask

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_ch.valid || digest_queue.size() > 0)
      @(posedge clk_i);
  endtask

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_words.size() > 0 && $urandom_range(0, 99) >= src_idle) begin
        drv_word = pending_words.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.op        <= drv_word.op;
        in_ch.data_byte <= drv_word.data;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result receiver with one long hold-off once a digest word is waiting
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      hold_left    <= 0;
      hold_taken   <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_req && !hold_taken && out_ch.valid) begin
      hold_taken   <= 1'b1;
      hold_left    <= HoldCycles;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= sink_idle);
    end
  end

  // monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_word_t w;
      digest_word_t want;
      if (in_ch.valid && in_ch.ready) begin
        w.op = op_e'(in_ch.op);
        w.data = in_ch.data_byte;
        md_apply(w);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (digest_queue.size() == 0) begin
          report("unexpected word", out_ch.digest_half, '0);
        end else begin
          want = digest_queue.pop_front();
          if (out_ch.digest_half !== want.half)
            report("digest_half", out_ch.digest_half, want.half);
          if (out_ch.digest_last !== want.last)
            report("digest_last", 64'(out_ch.digest_last), 64'(want.last));
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchLimit) begin
        $display("timeout");
        $display("CHECKS FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned lens[10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
    int unsigned phase_src[4] = '{0, 57, 0, 36};
    int unsigned phase_sink[4] = '{0, 0, 57, 36};
    int unsigned start;
    in_ch.valid = 1'b0;
    in_ch.op = 1'b0;
    in_ch.data_byte = 8'h00;
    out_ch.ready = 1'b0;
    src_idle = 0;
    sink_idle = 0;
    errors = 0;
    quiet_cycles = 0;
    hold_req = 1'b0;
    md_init();
    for (int i = 0; i < 64; i++) md_buf[i] = 8'h00;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty message, "abc", extreme bytes, back-to-back finishes
    push_bytes_and_finish(8'h00, 8'h00, 8'h00, 0);
    push_bytes_and_finish(8'h61, 8'h62, 8'h63, 3);
    push_bytes_and_finish(8'h00, 8'hff, 8'h00, 2);
    push_bytes_and_finish(8'hff, 8'hff, 8'hff, 3);
    push_bytes_and_finish(8'h00, 8'h00, 8'h00, 0);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      src_idle = phase_src[p];
      sink_idle = phase_sink[p];
      if (p == 0) hold_req = 1'b1;
      start = 0;
      while (start < 480) begin
        int unsigned len;
        if ($urandom_range(0, 9) < 5) len = $urandom_range(0, 12);
        else len = lens[$urandom_range(0, 9)];
        push_msg(len);
        start += len + 1;
      end
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0 && digest_queue.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
